// File: hdl/srs_pkg.sv
// ------------------------------------------------------------------------------------------------
// srs_pkg: shared definitions for the stereo fractional resampler
// Widths, register indexes, quality codes, lane control word and saturation helper.
// ------------------------------------------------------------------------------------------------
package srs_pkg;

   localparam int SAMPLE_W            = 16;
   localparam int RATIO_W             = 20;
   localparam int MODE_W              = 2;
   localparam int GAIN_W              = 17;
   localparam int CSR_IDX_W           = 4;
   localparam int CSR_DATA_W          = 20;
   localparam int WIN_DEPTH           = 4;
   localparam int FILL_W              = 3;
   localparam int MAX_RESULTS         = 64;
   localparam int CUBIC_BITS          = 14;
   localparam int LANE_LAT            = 10;
   localparam int PHASE_FRAC_BITS_DEF = 16;
   localparam int PHASE_INT_BITS      = 5;

   localparam logic [CSR_IDX_W-1:0] CSR_RATIO_STEP   = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_QUALITY_MODE = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN         = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MUTE         = 4'd3;

   localparam logic [MODE_W-1:0] QM_NEAREST = 2'd0;
   localparam logic [MODE_W-1:0] QM_LINEAR  = 2'd1;
   localparam logic [MODE_W-1:0] QM_CUBIC   = 2'd2;

   localparam logic [RATIO_W-1:0] RATIO_RESET = 20'd65536;
   localparam logic [MODE_W-1:0]  MODE_RESET  = QM_LINEAR;
   localparam logic [GAIN_W-1:0]  GAIN_RESET  = 17'd65536;

   localparam logic [FILL_W-1:0] FILL_FULL = 3'd4;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EMIT = 2'b10
   } seq_state_type;

   typedef struct packed {
      logic cubic;
      logic nearest;
      logic full_hist;
   } lane_ctl_type;

   function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [23:0] v);
      logic signed [SAMPLE_W-1:0] r;
      if (v < -24'sd32768) begin
         r = -16'sd32768;
      end else if (v > 24'sd32767) begin
         r = 16'sd32767;
      end else begin
         r = v[SAMPLE_W-1:0];
      end
      return r;
   endfunction

endpackage

// File: hdl/srs_if.sv
// ------------------------------------------------------------------------------------------------
// srs_if: channel interfaces of the stereo fractional resampler
// Source frame channel, output frame channel and register write channel.
// ------------------------------------------------------------------------------------------------
interface srs_req_if import srs_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] src_left;
   logic signed [SAMPLE_W-1:0] src_right;

   modport source (output valid, output src_left, output src_right, input ready);
   modport sink (input valid, input src_left, input src_right, output ready);
endinterface

interface srs_rsp_if import srs_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] out_left;
   logic signed [SAMPLE_W-1:0] out_right;
   logic                       last_of_run;

   modport source (output valid, output out_left, output out_right, output last_of_run,
                   input ready);
   modport sink (input valid, input out_left, input out_right, input last_of_run,
                 output ready);
endinterface

interface srs_csr_if import srs_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// File: hdl/srs_lane.sv
// ------------------------------------------------------------------------------------------------
// srs_lane: one channel of the resampler datapath
// Nearest, linear and Catmull-Rom interpolation, then volume scaling, in a ten-stage pipeline.
// ------------------------------------------------------------------------------------------------
module srs_lane import srs_pkg::*; #(
   parameter int PHASE_FRAC_BITS = PHASE_FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                en,
   input  lane_ctl_type                        ctl,
   input  logic [PHASE_FRAC_BITS-1:0]          t,
   input  logic [WIN_DEPTH-1:0][SAMPLE_W-1:0]  win,
   input  logic [GAIN_W-1:0]                   gain,
   input  logic                                mute,
   output logic signed [SAMPLE_W-1:0]          sample
);

   localparam int F      = PHASE_FRAC_BITS;
   localparam int CB     = CUBIC_BITS;
   localparam int LIN_W  = F + 18;
   localparam int CW     = 20;
   localparam int M1_W   = 36;
   localparam int M2_W   = 51;
   localparam int SPLIT  = 26;
   localparam int PP_W   = 40;
   localparam int N_W    = 64;
   localparam int CUB_SH = 3 * CUBIC_BITS + 1;
   localparam int GP_W   = 34;
   localparam logic [F-1:0]        LIN_HALF  = F'(1) << (F - 1);
   localparam logic [CUB_SH-1:0]   CUB_HALF  = CUB_SH'(1) << (CUB_SH - 1);
   localparam logic [15:0]         GAIN_HALF = 16'h8000;

   logic signed [SAMPLE_W-1:0] p0_c, p1_c, p2_c, p3_c, prev_c, cur_c;
   logic signed [CW-1:0]       e0, e1, e2, e3;
   logic signed [CW-1:0]       a_in, b_in, c_in;
   logic [F+CB-1:0]            t_wide;
   logic [CB-1:0]              tq_in;
   logic signed [16:0]         d_c;
   logic signed [LIN_W-1:0]    lin_prod_in;
   logic signed [SAMPLE_W-1:0] near_in;

   logic signed [SAMPLE_W-1:0] p1_ff [1:6];
   logic [CB-1:0]              tq_ff [1:5];
   logic signed [CW-1:0]       a_ff [1:4];
   logic signed [CW-1:0]       b_ff [1:2];
   logic signed [CW-1:0]       c_ff;
   logic                       cub_ff [1:7];
   logic                       near_sel_ff;
   logic signed [SAMPLE_W-1:0] prev_ff;
   logic signed [SAMPLE_W-1:0] near_ff;
   logic signed [LIN_W-1:0]    lin_prod_ff;
   logic signed [SAMPLE_W-1:0] lin_ff [2:7];

   logic signed [LIN_W-1:0]    lin_sum;
   logic signed [17:0]         lin_q;
   logic                       lin_inc;
   logic signed [SAMPLE_W-1:0] lin_in;

   logic signed [M1_W-1:0]     m1_in, m1_ff;
   logic signed [M1_W-1:0]     s2_in, s2_ff;
   logic signed [M2_W-1:0]     m2_in, m2_ff;
   logic signed [M2_W-1:0]     s3_in, s3_ff;
   logic signed [PP_W-1:0]     ph_in, ph_ff;
   logic [PP_W-1:0]            pl_in, pl_ff;
   logic signed [N_W-1:0]      n_in, n_ff;

   logic signed [N_W-CUB_SH-1:0] cub_q;
   logic                         cub_inc;
   logic signed [SAMPLE_W-1:0]   sel_in, sel_ff;

   logic signed [GP_W-1:0]       gp_in, gp_ff;
   logic signed [SAMPLE_W-1:0]   pass_ff;
   logic signed [17:0]           g_q;
   logic                         g_inc;
   logic signed [SAMPLE_W-1:0]   out_in, out_ff;

   always_comb begin
      p1_c   = $signed(win[2]);
      p0_c   = ctl.full_hist ? $signed(win[3]) : p1_c;
      p2_c   = $signed(win[1]);
      p3_c   = $signed(win[0]);
      e0     = CW'(p0_c);
      e1     = CW'(p1_c);
      e2     = CW'(p2_c);
      e3     = CW'(p3_c);
      a_in   = e2 - e0;
      b_in   = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
      c_in   = (e1 <<< 1) + e1 - e0 - (e2 <<< 1) - e2 + e3;
      t_wide = (F + CB)'(t) << CB;
      t_wide = t_wide >> F;
      tq_in  = t_wide[CB-1:0];
      prev_c = $signed(win[1]);
      cur_c  = $signed(win[0]);
      d_c    = 17'(cur_c) - 17'(prev_c);
      lin_prod_in = LIN_W'(d_c) * LIN_W'($signed({1'b0, t}));
      near_in     = t[F-1] ? cur_c : prev_c;
   end

   always_comb begin
      lin_sum = (LIN_W'(prev_ff) <<< F) + lin_prod_ff;
      lin_q   = lin_sum[LIN_W-1:F];
      lin_inc = (lin_sum[F-1:0] > LIN_HALF) || ((lin_sum[F-1:0] == LIN_HALF) && lin_q[0]);
      lin_in  = near_sel_ff ? near_ff : sat16(24'(lin_q) + $signed(24'(lin_inc)));

      m1_in = M1_W'(c_ff) * M1_W'($signed({1'b0, tq_ff[1]}));
      s2_in = (M1_W'(b_ff[2]) <<< CB) + m1_ff;
      m2_in = M2_W'(s2_ff) * M2_W'($signed({1'b0, tq_ff[3]}));
      s3_in = (M2_W'(a_ff[4]) <<< (2 * CB)) + m2_ff;
      ph_in = PP_W'($signed(s3_ff[M2_W-1:SPLIT])) * PP_W'($signed({1'b0, tq_ff[5]}));
      pl_in = PP_W'(s3_ff[SPLIT-1:0]) * PP_W'(tq_ff[5]);
      n_in  = (N_W'(p1_ff[6]) <<< (CUB_SH)) + (N_W'(ph_ff) <<< SPLIT) + $signed(N_W'(pl_ff));

      cub_q   = n_ff[N_W-1:CUB_SH];
      cub_inc = (n_ff[CUB_SH-1:0] > CUB_HALF) ||
                ((n_ff[CUB_SH-1:0] == CUB_HALF) && cub_q[0]);
      sel_in  = cub_ff[7] ? sat16(24'(cub_q) + $signed(24'(cub_inc))) : lin_ff[7];

      gp_in = GP_W'(sel_ff) * GP_W'($signed({1'b0, gain}));
      g_q   = gp_ff[GP_W-1:16];
      g_inc = (gp_ff[15:0] > GAIN_HALF) || ((gp_ff[15:0] == GAIN_HALF) && g_q[0]);
      if (mute || (gain == '0)) begin
         out_in = '0;
      end else if (gain[GAIN_W-1]) begin
         out_in = pass_ff;
      end else begin
         out_in = sat16(24'(g_q) + $signed(24'(g_inc)));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff[1]    <= p1_c;
         tq_ff[1]    <= tq_in;
         a_ff[1]     <= a_in;
         b_ff[1]     <= b_in;
         c_ff        <= c_in;
         cub_ff[1]   <= ctl.cubic;
         near_sel_ff <= ctl.nearest;
         prev_ff     <= prev_c;
         near_ff     <= near_in;
         lin_prod_ff <= lin_prod_in;
         for (int i = 2; i <= 6; i++) p1_ff[i] <= p1_ff[i-1];
         for (int i = 2; i <= 5; i++) tq_ff[i] <= tq_ff[i-1];
         for (int i = 2; i <= 4; i++) a_ff[i] <= a_ff[i-1];
         b_ff[2] <= b_ff[1];
         for (int i = 2; i <= 7; i++) cub_ff[i] <= cub_ff[i-1];
         lin_ff[2] <= lin_in;
         for (int i = 3; i <= 7; i++) lin_ff[i] <= lin_ff[i-1];
         m1_ff   <= m1_in;
         s2_ff   <= s2_in;
         m2_ff   <= m2_in;
         s3_ff   <= s3_in;
         ph_ff   <= ph_in;
         pl_ff   <= pl_in;
         n_ff    <= n_in;
         sel_ff  <= sel_in;
         gp_ff   <= gp_in;
         pass_ff <= sel_ff;
         out_ff  <= out_in;
      end
   end

   assign sample = out_ff;

endmodule

// File: hdl/stereo_fractional_resampler.sv
// ------------------------------------------------------------------------------------------------
// stereo_fractional_resampler: stereo fractional-rate audio resampler
// Flow: an accepted source word shifts into the window; the phase sequencer then issues its
// output words through its single issue slot into the lanes, one output word per cycle while
// the output is not stalled. The input is not ready until all output words of a source word
// are issued; while the window is still filling, no output is issued and the input stays ready.
// Reset: registers take their defaults; window, fill count, phase and pipeline valid flags clear.
// ------------------------------------------------------------------------------------------------
module stereo_fractional_resampler import srs_pkg::*; #(
   parameter int PHASE_FRAC_BITS = PHASE_FRAC_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   srs_req_if.sink    req_if,
   srs_rsp_if.source  rsp_if,
   srs_csr_if.sink    csr_if
);

   localparam int PW    = PHASE_FRAC_BITS + PHASE_INT_BITS;
   localparam int SW_W  = PW + 16;
   localparam int CNT_W = $clog2(MAX_RESULTS + 1);
   localparam logic [PW-1:0]    PHASE_ONE   = PW'(1) << PHASE_FRAC_BITS;
   localparam logic [PW-1:0]    PHASE_BOUND = PW'(17) << PHASE_FRAC_BITS;
   localparam logic [CNT_W-1:0] CNT_LAST    = CNT_W'(MAX_RESULTS - 1);

   logic [RATIO_W-1:0] ratio_ff, ratio_in;
   logic [MODE_W-1:0]  mode_ff, mode_in;
   logic [GAIN_W-1:0]  gain_ff, gain_in;
   logic               mute_ff, mute_in;

   logic [WIN_DEPTH-1:0][SAMPLE_W-1:0] win_l_ff, win_l_in, win_r_ff, win_r_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [PW-1:0]      phase_ff, phase_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   seq_state_type      state_ff, state_in;

   logic [LANE_LAT-1:0] vld_ff, vld_in, lst_ff, lst_in;

   logic                       out_valid_ff;
   logic signed [SAMPLE_W-1:0] out_left_ff, out_right_ff;
   logic                       out_last_ff;

   logic               en, req_accept, below_one, issue, issue_last;
   logic [FILL_W-1:0]  need;
   logic [SW_W-1:0]    step_wide;
   logic [PW-1:0]      step, phase_next;
   lane_ctl_type       ctl;
   logic signed [SAMPLE_W-1:0] lane_left, lane_right;

   assign en         = !out_valid_ff || rsp_if.ready;
   assign req_accept = req_if.valid && req_if.ready;
   assign req_if.ready = (state_ff == ST_IDLE);
   assign csr_if.ready = 1'b1;

   always_comb begin
      step_wide  = SW_W'(ratio_ff) << PHASE_FRAC_BITS;
      step       = step_wide[SW_W-1:16];
      need       = (mode_ff == QM_CUBIC) ? 3'd3 : 3'd2;
      below_one  = phase_ff < PHASE_ONE;
      phase_next = phase_ff + step;
      issue      = (state_ff == ST_EMIT) && below_one && en;
      issue_last = (phase_next >= PHASE_ONE) || (cnt_ff == CNT_LAST);

      ctl.cubic     = (mode_ff == QM_CUBIC);
      ctl.nearest   = (mode_ff == QM_NEAREST);
      ctl.full_hist = (fill_ff == FILL_FULL);

      ratio_in = ratio_ff;
      mode_in  = mode_ff;
      gain_in  = gain_ff;
      mute_in  = mute_ff;
      if (csr_if.valid && csr_if.ready) begin
         case (csr_if.index)
            CSR_RATIO_STEP:   ratio_in = csr_if.data[RATIO_W-1:0];
            CSR_QUALITY_MODE: mode_in  = csr_if.data[MODE_W-1:0];
            CSR_GAIN:         gain_in  = csr_if.data[GAIN_W-1:0];
            CSR_MUTE:         mute_in  = csr_if.data[0];
            default:          ;
         endcase
      end

      win_l_in = win_l_ff;
      win_r_in = win_r_ff;
      fill_in  = fill_ff;
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               win_l_in = {win_l_ff[WIN_DEPTH-2:0], req_if.src_left};
               win_r_in = {win_r_ff[WIN_DEPTH-2:0], req_if.src_right};
               if (fill_ff < FILL_FULL) begin
                  fill_in = fill_ff + 3'd1;
               end
               if ((fill_ff >= need) && !below_one) begin
                  phase_in = phase_ff - PHASE_ONE;
               end
               cnt_in = '0;
               if (fill_in >= need) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (!below_one) begin
               state_in = ST_IDLE;
            end else if (en) begin
               phase_in = phase_next;
               cnt_in   = cnt_ff + CNT_W'(1);
               if (issue_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      vld_in = {vld_ff[LANE_LAT-2:0], issue};
      lst_in = {lst_ff[LANE_LAT-2:0], issue_last};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ratio_ff     <= RATIO_RESET;
         mode_ff      <= MODE_RESET;
         gain_ff      <= GAIN_RESET;
         mute_ff      <= 1'b0;
         win_l_ff     <= '0;
         win_r_ff     <= '0;
         fill_ff      <= '0;
         phase_ff     <= '0;
         cnt_ff       <= '0;
         state_ff     <= ST_IDLE;
         vld_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         ratio_ff <= ratio_in;
         mode_ff  <= mode_in;
         gain_ff  <= gain_in;
         mute_ff  <= mute_in;
         win_l_ff <= win_l_in;
         win_r_ff <= win_r_in;
         fill_ff  <= fill_in;
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         state_ff <= state_in;
         if (en) begin
            vld_ff       <= vld_in;
            out_valid_ff <= vld_ff[LANE_LAT-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lst_ff       <= lst_in;
         out_left_ff  <= lane_left;
         out_right_ff <= lane_right;
         out_last_ff  <= lst_ff[LANE_LAT-1];
      end
   end

   srs_lane #(.PHASE_FRAC_BITS(PHASE_FRAC_BITS)) u_lane_left (
      .clock  (clock),
      .en     (en),
      .ctl    (ctl),
      .t      (phase_ff[PHASE_FRAC_BITS-1:0]),
      .win    (win_l_ff),
      .gain   (gain_ff),
      .mute   (mute_ff),
      .sample (lane_left)
   );

   srs_lane #(.PHASE_FRAC_BITS(PHASE_FRAC_BITS)) u_lane_right (
      .clock  (clock),
      .en     (en),
      .ctl    (ctl),
      .t      (phase_ff[PHASE_FRAC_BITS-1:0]),
      .win    (win_r_ff),
      .gain   (gain_ff),
      .mute   (mute_ff),
      .sample (lane_right)
   );

   assign rsp_if.valid       = out_valid_ff;
   assign rsp_if.out_left    = out_left_ff;
   assign rsp_if.out_right   = out_right_ff;
   assign rsp_if.last_of_run = out_last_ff;

   a_phase_bound: assert property (@(posedge clock) disable iff (reset)
      phase_ff < PHASE_BOUND)
      else $error("phase accumulator beyond its range");

   a_emit_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (cnt_ff < CNT_W'(MAX_RESULTS)))
      else $error("more output words than allowed for one source word");

   a_emit_fill: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (fill_ff >= 3'd2))
      else $error("output issued without enough source frames");

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_FULL)
      else $error("window fill count out of range");

endmodule
